### rtl/core/rcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary encoder decoder package
// Shared types, register codes, reset values and the pin-to-code mapping.
// ----------------------------------------------------------------------------
package rcd_pkg;

	localparam int CfgIndexWidth = 2;

	localparam logic [CfgIndexWidth-1:0] CFG_CHECK_INTERVAL = 2'd0;
	localparam logic [CfgIndexWidth-1:0] CFG_HOLD_LIMIT     = 2'd1;
	localparam logic [CfgIndexWidth-1:0] CFG_DCLICK_WINDOW  = 2'd2;

	localparam logic [15:0] CHECK_INTERVAL_RST = 16'd1500;
	localparam logic [15:0] HOLD_LIMIT_RST     = 16'd500;
	localparam logic [15:0] DCLICK_WINDOW_RST  = 16'd1000;

	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_READ   = 1'b1;

	localparam logic [1:0] EV_NONE   = 2'd0;
	localparam logic [1:0] EV_CLICK  = 2'd1;
	localparam logic [1:0] EV_DCLICK = 2'd2;

	typedef struct packed {
		logic        action;
		logic [1:0]  enc_pins;
		logic        button_down;
		logic [31:0] now_ms;
	} item_t;

	typedef struct packed {
		logic [15:0] check_interval_ms;
		logic [15:0] hold_limit;
		logic [15:0] dclick_window;
	} cfg_t;

	function automatic logic [1:0] pins_to_code(input logic [1:0] pins);
		logic [1:0] code;
		case (pins)
			2'd1:    code = 2'd1;
			2'd2:    code = 2'd3;
			default: code = 2'd2;
		endcase
		return code;
	endfunction

endpackage

### rtl/core/rcd_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary encoder decoder input register
// Captures one input transfer and holds it until the core takes it.
// ----------------------------------------------------------------------------
module rcd_in_reg
	import rcd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  item_t       item,
	input  logic        advance,
	output logic        valid_s1,
	output item_t       item_s1
);

	logic load;

	assign in_stall = valid_s1 && !advance;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item;
		end
	end

endmodule

### rtl/core/rcd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary encoder decoder core
// Step accumulator, button check state and the result register.
// ----------------------------------------------------------------------------
module rcd_core
	import rcd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               valid_s1,
	input  item_t              item_s1,
	output logic               advance,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] step_total,
	output logic [1:0]         button_event
);

	logic [1:0]         prev_code_q;
	logic signed [15:0] step_accum_q;
	logic [15:0]        press_checks_q;
	logic signed [16:0] dclick_timer_q;
	logic [31:0]        last_check_ms_q;
	logic [1:0]         button_latch_q;
	logic               out_valid_q;
	logic signed [15:0] step_total_q;
	logic [1:0]         button_event_q;

	logic               fire;
	logic [1:0]         cur_code;
	logic [1:0]         diff;
	logic [31:0]        elapsed;
	logic               check;
	logic [1:0]         prev_code_d;
	logic signed [15:0] step_accum_d;
	logic signed [15:0] reported;
	logic [15:0]        press_checks_d;
	logic signed [16:0] timer_a;
	logic signed [16:0] timer_b;
	logic signed [16:0] timer_d;
	logic signed [16:0] window;
	logic [1:0]         latch_a;
	logic [1:0]         latch_d;

	assign advance = !(out_valid_q && out_stall);
	assign fire    = valid_s1 && advance;

	assign cur_code = pins_to_code(item_s1.enc_pins);
	assign diff     = prev_code_q - cur_code;
	assign elapsed  = item_s1.now_ms - last_check_ms_q;
	assign check    = elapsed >= {16'd0, cfg.check_interval_ms};
	assign window   = $signed({1'b0, cfg.dclick_window});
	assign timer_b  = timer_a - 17'sd2;

	always_comb begin
		prev_code_d  = prev_code_q;
		step_accum_d = step_accum_q;
		if (diff[0]) begin
			prev_code_d = cur_code;
			if (diff[1]) begin
				if (step_accum_q != 16'sh7FFF) begin
					step_accum_d = step_accum_q + 16'sd1;
				end
			end else begin
				if (step_accum_q != -16'sh8000) begin
					step_accum_d = step_accum_q - 16'sd1;
				end
			end
		end
	end

	always_comb begin
		press_checks_d = press_checks_q;
		timer_a        = dclick_timer_q;
		latch_a        = button_latch_q;
		if (item_s1.button_down) begin
			if (press_checks_q != 16'hFFFF) begin
				press_checks_d = press_checks_q + 16'd1;
			end
		end else begin
			if (press_checks_q != 16'd0) begin
				if (press_checks_q > cfg.hold_limit) begin
					timer_a = 17'sd0;
				end else if (dclick_timer_q > 17'sd1) begin
					if (dclick_timer_q < window) begin
						latch_a = EV_DCLICK;
						timer_a = 17'sd0;
					end
				end else begin
					timer_a = window;
				end
			end
			press_checks_d = 16'd0;
		end
		timer_d = timer_a;
		latch_d = latch_a;
		if (timer_a > 17'sd0) begin
			timer_d = timer_b;
			if (timer_b == 17'sd0) begin
				latch_d = EV_CLICK;
			end
		end
	end

	assign reported = (item_s1.action == ACT_READ) ? step_accum_q : step_accum_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_code_q     <= 2'd0;
			step_accum_q    <= 16'sd0;
			press_checks_q  <= 16'd0;
			dclick_timer_q  <= 17'sd0;
			last_check_ms_q <= 32'd0;
			button_latch_q  <= EV_NONE;
		end else if (fire) begin
			if (item_s1.action == ACT_READ) begin
				step_accum_q <= 16'sd0;
			end else begin
				prev_code_q  <= prev_code_d;
				step_accum_q <= step_accum_d;
				if (check) begin
					last_check_ms_q <= item_s1.now_ms;
					press_checks_q  <= press_checks_d;
					dclick_timer_q  <= timer_d;
					button_latch_q  <= latch_d;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			step_total_q   <= reported;
			button_event_q <= (item_s1.action == ACT_SAMPLE && check) ? latch_d
				: button_latch_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign step_total   = step_total_q;
	assign button_event = button_event_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		button_latch_q != 2'd3)
		else $error("Button latch holds an undefined event code.");

	assert property (@(posedge clk) disable iff (!arst_n)
		dclick_timer_q >= -17'sd1)
		else $error("Double-click timer fell below minus one.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_s1.action == ACT_READ) |=> step_accum_q == 16'sd0)
		else $error("Step total not cleared after a read transfer.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(button_latch_q != EV_NONE) |=> (button_latch_q != EV_NONE))
		else $error("Button event lost its sticky value.");

	assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q && step_total_q == $past(reported))
		else $error("Result register did not take the processed item.");

endmodule

### rtl/core/rotary_encoder_click_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary encoder click decoder
// Quadrature step counting with click and double-click detection.
// ----------------------------------------------------------------------------
// The block takes one item per clock and returns one result per item, each
// passing the input register and then the output register. An item is held
// in the input register and is processed in a single pass against the step
// and button state, which is updated at the same edge, so the following item
// already sees it. Input is stalled only while a result waits in the output
// register and the output side is stalled. Configuration writes are always
// ready and take effect at once.
module rotary_encoder_click_decoder
	import rcd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     action,
	input  logic [1:0]               enc_pins,
	input  logic                     button_down,
	input  logic [31:0]              now_ms,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [15:0]       step_total,
	output logic [1:0]               button_event,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CfgIndexWidth-1:0] cfg_index,
	input  logic [15:0]              cfg_data
);

	cfg_t  cfg_q;
	item_t item;
	item_t item_s1;
	logic  valid_s1;
	logic  advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.check_interval_ms <= CHECK_INTERVAL_RST;
			cfg_q.hold_limit        <= HOLD_LIMIT_RST;
			cfg_q.dclick_window     <= DCLICK_WINDOW_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CHECK_INTERVAL: cfg_q.check_interval_ms <= cfg_data;
				CFG_HOLD_LIMIT:     cfg_q.hold_limit        <= cfg_data;
				CFG_DCLICK_WINDOW:  cfg_q.dclick_window     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign item.action      = action;
	assign item.enc_pins    = enc_pins;
	assign item.button_down = button_down;
	assign item.now_ms      = now_ms;

	rcd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.item     (item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	rcd_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.valid_s1     (valid_s1),
		.item_s1      (item_s1),
		.advance      (advance),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.step_total   (step_total),
		.button_event (button_event)
	);

endmodule

### dv/rotary_encoder_click_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary encoder click decoder testbench
// Drives sample and read transfers under several register settings, with
// random idling on both sides. A step and button tracker works out the
// expected total and event for every accepted transfer, and each result is
// compared against it in order.
// ----------------------------------------------------------------------------
module rotary_encoder_click_decoder_test;
	import rcd_pkg::*;

	localparam int QuietLimit = 4000;
	localparam int HoldOffCycles = 300;
	localparam int NumSettings = 9;
	localparam int ItemsPerSetting = 66;

	typedef struct packed {
		logic signed [15:0] total;
		logic [1:0]         button_ev;
	} reading_t;

	class step_button_tracker;
		logic [15:0]        check_interval;
		logic [15:0]        hold_limit;
		logic [15:0]        dclick_window;
		logic [1:0]         prev_code;
		logic signed [15:0] step_accum;
		logic [15:0]        press_checks;
		logic signed [16:0] dclick_timer;
		logic [31:0]        last_check_ms;
		logic [1:0]         latched_event;
		reading_t           pending_readings[$];
		int                 mismatches;

		function new();
			check_interval = CHECK_INTERVAL_RST;
			hold_limit = HOLD_LIMIT_RST;
			dclick_window = DCLICK_WINDOW_RST;
			prev_code = 2'd0;
			step_accum = 16'sd0;
			press_checks = 16'd0;
			dclick_timer = 17'sd0;
			last_check_ms = 32'd0;
			latched_event = EV_NONE;
			mismatches = 0;
		endfunction

		function void set_reg(logic [CfgIndexWidth-1:0] idx, logic [15:0] val);
			case (idx)
				CFG_CHECK_INTERVAL: check_interval = val;
				CFG_HOLD_LIMIT:     hold_limit = val;
				CFG_DCLICK_WINDOW:  dclick_window = val;
				default: ;
			endcase
		endfunction

		function logic [1:0] code_of(logic [1:0] pins);
			logic [1:0] code;
			code = 2'd2;
			if (pins == 2'd1) code = 2'd1;
			else if (pins == 2'd2) code = 2'd3;
			return code;
		endfunction

		function void advance_button(logic down);
			if (down) begin
				if (press_checks != 16'hFFFF) press_checks = press_checks + 16'd1;
			end else begin
				if (press_checks != 16'd0) begin
					if (press_checks > hold_limit) begin
						dclick_timer = 17'sd0;
					end else if (dclick_timer > 17'sd1) begin
						if (dclick_timer < $signed({1'b0, dclick_window})) begin
							latched_event = EV_DCLICK;
							dclick_timer = 17'sd0;
						end
					end else begin
						dclick_timer = $signed({1'b0, dclick_window});
					end
				end
				press_checks = 16'd0;
			end
			if (dclick_timer > 17'sd0) begin
				dclick_timer = dclick_timer - 17'sd2;
				if (dclick_timer == 17'sd0) latched_event = EV_CLICK;
			end
		endfunction

		function void take_item(item_t smp);
			reading_t   want;
			logic [1:0] cur;
			logic [1:0] diff;
			logic [31:0] elapsed;
			if (smp.action == ACT_READ) begin
				want.total = step_accum;
				step_accum = 16'sd0;
			end else begin
				cur = code_of(smp.enc_pins);
				diff = prev_code - cur;
				if (diff[0]) begin
					prev_code = cur;
					if (diff[1]) begin
						if (step_accum != 16'sh7FFF) step_accum = step_accum + 16'sd1;
					end else begin
						if (step_accum != 16'sh8000) step_accum = step_accum - 16'sd1;
					end
				end
				elapsed = smp.now_ms - last_check_ms;
				if (elapsed >= {16'd0, check_interval}) begin
					last_check_ms = smp.now_ms;
					advance_button(smp.button_down);
				end
				want.total = step_accum;
			end
			want.button_ev = latched_event;
			pending_readings.push_back(want);
		endfunction

		function void flag(string what);
			mismatches++;
			if (mismatches <= 10) $display("%t: %s", $realtime, what);
		endfunction

		function void check_reading(logic signed [15:0] total, logic [1:0] ev);
			reading_t want;
			if (pending_readings.size() == 0) begin
				flag($sformatf("result with nothing expected: step_total %0d button_event %0d",
					total, ev));
			end else begin
				want = pending_readings.pop_front();
				if (total !== want.total)
					flag($sformatf("step_total: expected %0d, got %0d", want.total, total));
				if (ev !== want.button_ev)
					flag($sformatf("button_event: expected %0d, got %0d", want.button_ev, ev));
			end
		endfunction

		function int outstanding();
			return pending_readings.size();
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic                     action;
	logic [1:0]               enc_pins;
	logic                     button_down;
	logic [31:0]              now_ms;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [15:0]       step_total;
	logic [1:0]               button_event;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CfgIndexWidth-1:0] cfg_index;
	logic [15:0]              cfg_data;

	step_button_tracker scores = new();

	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          hold_len = 0;
	int          press_max = 4;
	int          release_max = 4;
	int          btn_run = 0;
	logic        btn_level = 1'b0;
	logic [31:0] t_ms = 32'd0;

	rotary_encoder_click_decoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.enc_pins     (enc_pins),
		.button_down  (button_down),
		.now_ms       (now_ms),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.step_total   (step_total),
		.button_event (button_event),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// A long hold-off is counted here while the sender keeps offering transfers.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len != 0) begin
				out_stall <= 1'b1;
				for (int n = 0; n < hold_len; n++) @(posedge clk);
				hold_len = 0;
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) scores.check_reading(step_total, button_event);
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QuietLimit) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("** rotary_encoder_click_decoder: FAILED **");
		$finish;
	end

	task automatic send_item(input item_t smp);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= smp.action;
		enc_pins <= smp.enc_pins;
		button_down <= smp.button_down;
		now_ms <= smp.now_ms;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		scores.take_item(smp);
	endtask

	task automatic sample_pins(input logic [1:0] pins, input logic down, input logic [31:0] at);
		item_t smp;
		smp.action = ACT_SAMPLE;
		smp.enc_pins = pins;
		smp.button_down = down;
		smp.now_ms = at;
		send_item(smp);
	endtask

	task automatic read_total();
		item_t smp;
		smp.action = ACT_READ;
		smp.enc_pins = 2'($urandom_range(3));
		smp.button_down = 1'($urandom_range(1));
		smp.now_ms = $urandom();
		send_item(smp);
	endtask

	// One sample at exactly the next check time.
	task automatic tick(input logic down);
		t_ms = t_ms + {16'd0, scores.check_interval};
		sample_pins(2'($urandom_range(3)), down, t_ms);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (scores.outstanding() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		scores.set_reg(idx, val);
	endtask

	task automatic apply_setting(input logic [15:0] interval, input logic [15:0] hold,
		input logic [15:0] window);
		drain();
		write_reg(CFG_CHECK_INTERVAL, interval);
		write_reg(CFG_HOLD_LIMIT, hold);
		write_reg(CFG_DCLICK_WINDOW, window);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_item(output item_t smp);
		int          roll;
		logic [31:0] gap;
		smp.action = ACT_SAMPLE;
		smp.enc_pins = 2'($urandom_range(3));
		smp.button_down = 1'($urandom_range(1));
		smp.now_ms = $urandom();
		if ($urandom_range(99) < 12) begin
			smp.action = ACT_READ;
		end else begin
			if (btn_run == 0) begin
				btn_level = ~btn_level;
				btn_run = btn_level ? $urandom_range(1, press_max) : $urandom_range(1, release_max);
			end
			btn_run--;
			smp.button_down = ($urandom_range(99) < 5) ? ~btn_level : btn_level;
			gap = {16'd0, scores.check_interval};
			roll = $urandom_range(99);
			if (roll < 65) t_ms = t_ms + gap;
			else if (roll < 75) t_ms = t_ms + gap - 32'd1;
			else if (roll < 85) t_ms = t_ms + $urandom_range(0, 2 * gap);
			else if (roll < 92) t_ms = t_ms;
			else if (roll < 97) t_ms = t_ms + $urandom_range(32'h0001_0000, 32'h7FFF_FFFF);
			else t_ms = $urandom();
			smp.now_ms = t_ms;
		end
	endtask

	task automatic run_setting(input int idx, input logic [15:0] interval,
		input logic [15:0] hold, input logic [15:0] window);
		item_t smp;
		apply_setting(interval, hold, window);
		press_max = (hold < 16'd6) ? int'(hold) + 2 : 5;
		release_max = (window < 16'd16) ? int'(window) / 2 + 2 : 6;
		for (int n = 0; n < ItemsPerSetting; n++) begin
			random_item(smp);
			if (idx == 6 && n == 20) hold_len = HoldOffCycles;
			send_item(smp);
		end
	endtask

	initial begin
		logic [15:0] intervals [NumSettings];
		logic [15:0] holds [NumSettings];
		logic [15:0] windows [NumSettings];
		intervals = '{16'd1, 16'd2, 16'd1, 16'd3, 16'd65535, 16'd5, 16'd1500, 16'd1, 16'd1};
		holds = '{16'd1, 16'd3, 16'd4, 16'd2, 16'd65535, 16'd6, 16'd500, 16'd65535, 16'd1};
		windows = '{16'd2, 16'd6, 16'd10, 16'd8, 16'd65534, 16'd12, 16'd1000, 16'd14, 16'd2};
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		action <= ACT_SAMPLE;
		enc_pins <= 2'd0;
		button_down <= 1'b0;
		now_ms <= 32'd0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_CHECK_INTERVAL;
		cfg_data <= 16'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 17;
		stall_pct = 88;
		read_total();
		sample_pins(2'd0, 1'b0, 32'd0);
		sample_pins(2'd1, 1'b0, 32'd1499);
		sample_pins(2'd3, 1'b1, 32'd1500);
		sample_pins(2'd2, 1'b1, 32'hFFFF_FFFF);
		sample_pins(2'd3, 1'b0, 32'd1000);
		read_total();
		sample_pins(2'd1, 1'b1, 32'd2600);
		read_total();

		// The press left over from above is released as a click.
		apply_setting(16'd1, 16'd3, 16'd8);
		t_ms = 32'd5000;
		repeat (4) tick(1'b0);
		tick(1'b1);
		tick(1'b0);
		tick(1'b1);
		tick(1'b0);
		repeat (4) tick(1'b1);
		tick(1'b0);
		tick(1'b1);
		tick(1'b0);

		// Window shrinks below the running timer: the next click is ignored.
		apply_setting(16'd1, 16'd3, 16'd4);
		tick(1'b1);
		tick(1'b0);
		tick(1'b0);

		// An odd window lets the timer settle at minus one without an event.
		apply_setting(16'd1, 16'd3, 16'd5);
		tick(1'b1);
		repeat (3) tick(1'b0);
		tick(1'b1);
		repeat (3) tick(1'b0);

		intervals[NumSettings-1] = 16'($urandom_range(1, 4));
		holds[NumSettings-1] = 16'($urandom_range(1, 6));
		windows[NumSettings-1] = 16'(2 * $urandom_range(1, 8));
		for (int s = 0; s < NumSettings; s++) begin
			if (s < 3) begin
				send_idle_pct = 17;
				stall_pct = 88;
			end else if (s < 6) begin
				send_idle_pct = 88;
				stall_pct = 17;
			end else begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			run_setting(s, intervals[s], holds[s], windows[s]);
		end

		drain();
		repeat (8) @(posedge clk);
		if (scores.mismatches == 0 && scores.outstanding() == 0) begin
			$display("** rotary_encoder_click_decoder: PASSED **");
		end else begin
			$display("** rotary_encoder_click_decoder: FAILED **");
		end
		$finish;
	end

endmodule

### rotary_encoder_click_decoder.f
rtl/core/rcd_pkg.sv
rtl/core/rcd_in_reg.sv
rtl/core/rcd_core.sv
rtl/core/rotary_encoder_click_decoder.sv
dv/rotary_encoder_click_decoder_test.sv
